### sv/sapa_pkg.sv
// ----------------------------------------------------------------------------
// Subnet address pool package
// Shared widths, codes and bitmap geometry of the address pool allocator.
// ----------------------------------------------------------------------------
package sapa_pkg;

	localparam int ADDR_W            = 32;
	localparam int CMD_W             = 2;
	localparam int STATUS_W          = 3;
	localparam int CFG_IDX_W         = 1;
	localparam int HOST_BITS_DEFAULT = 10;
	localparam logic [ADDR_W-1:0] MASK_RESET = 32'hFFFF_FC00;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_CLAIM   = 2'd1,
		CMD_RELEASE = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK            = 3'd0,
		ST_EXHAUSTED     = 3'd1,
		ST_NOT_IN_SUBNET = 3'd2,
		ST_INVALID_HOST  = 3'd3,
		ST_IN_USE        = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SUBNET_BASE = 1'd0,
		CFG_SUBNET_MASK = 1'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_MODIFY,
		S_SCAN,
		S_PUT
	} state_t;

	// bitmap rows are up to 32 bits wide, and there are always at least two rows
	function automatic int row_bits(input int host_bits);
		return (host_bits - 1 < 5) ? host_bits - 1 : 5;
	endfunction

endpackage

### sv/sapa_if.sv
// ----------------------------------------------------------------------------
// Subnet address pool channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sapa_req_if;
	logic                           valid;
	logic                           ready;
	logic [sapa_pkg::CMD_W-1:0]     command;
	logic [sapa_pkg::ADDR_W-1:0]    address;

	modport source (output valid, output command, output address, input ready);
	modport sink   (input valid, input command, input address, output ready);
endinterface

interface sapa_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [sapa_pkg::ADDR_W-1:0]    assigned_address;
	logic [sapa_pkg::STATUS_W-1:0]  status;

	modport source (output valid, output assigned_address, output status, input ready);
	modport sink   (input valid, input assigned_address, input status, output ready);
endinterface

### sv/sapa_bitmap.sv
// ----------------------------------------------------------------------------
// Used-host bitmap
// Single-port row memory of the used-host bits, registered read data.
// ----------------------------------------------------------------------------
module sapa_bitmap #(
	parameter int HOST_BITS = sapa_pkg::HOST_BITS_DEFAULT
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic                                          re,
	input  logic [HOST_BITS-sapa_pkg::row_bits(HOST_BITS)-1:0] addr,
	input  logic [(1 << sapa_pkg::row_bits(HOST_BITS))-1:0]    wdata,
	output logic [(1 << sapa_pkg::row_bits(HOST_BITS))-1:0]    rdata
);

	localparam int RB   = sapa_pkg::row_bits(HOST_BITS);
	localparam int RW   = 1 << RB;
	localparam int ROWS = 1 << (HOST_BITS - RB);

	logic [RW-1:0] mem [ROWS];
	logic [RW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/subnet_address_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// Subnet address pool allocator
// Next-fit bitmap allocator for the host addresses of one IPv4 subnet.
// ----------------------------------------------------------------------------
// Usage:
//   req carries a command (allocate, claim, release) and an address; rsp
//   returns one word per command: the allocated address and a status.
//   subnet_base and subnet_mask are written through cfg_we/cfg_index/cfg_data
//   while the block is idle. Allocate only proposes an address; claim it after.
//   Path of a command from accept to rsp.valid: claim and release of a valid
//   host go through decode, modify and put; unknown commands, addresses
//   outside the subnet, invalid hosts and allocate on an empty pool go from
//   decode straight to put. Allocate goes through decode, scan and put; the
//   scan reads one row of up to 32 bits per cycle from the single-port bitmap,
//   each row once and the start row again after the wrap.
//   One command is processed at a time; req.ready is high only when idle, so
//   a new command is accepted only once the previous one has left PUT.
//   After reset the bitmap is cleared in a pass over all rows, during which no
//   request is taken; config writes still land.
//   A stalled response is held in the output register; the next request is
//   accepted and processed meanwhile and waits before its own response.
// ----------------------------------------------------------------------------
module subnet_address_pool_allocator_unit #(
	parameter int HOST_BITS = sapa_pkg::HOST_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sapa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sapa_pkg::ADDR_W-1:0]       cfg_data,
	sapa_req_if.sink                          req,
	sapa_rsp_if.source                        rsp
);

	localparam int HB   = HOST_BITS;
	localparam int RB   = sapa_pkg::row_bits(HOST_BITS);
	localparam int RW   = 1 << RB;
	localparam int RI   = HB - RB;
	localparam int AW   = sapa_pkg::ADDR_W;
	localparam int MAP_SIZE = 1 << HB;
	localparam logic [AW-1:0] MAX_HOSTS = AW'(MAP_SIZE - 2);

	sapa_pkg::state_t  state_q, state_d;
	logic [RI-1:0]     clr_q;

	logic [AW-1:0]     base_q, mask_q;
	logic [HB-1:0]     next_q;

	sapa_pkg::cmd_t    cmd_q;
	logic [AW-1:0]     addr_q;
	logic [HB-1:0]     n_q, start_q, last_q, idx_q;
	logic [RI-1:0]     row_q;
	logic              phase_b_q;

	logic [AW-1:0]     res_addr_q;
	sapa_pkg::status_t res_status_q;
	logic              rsp_valid_q;
	logic [AW-1:0]     rsp_addr_q;
	sapa_pkg::status_t rsp_status_q;

	logic              mem_we, mem_re;
	logic [RI-1:0]     mem_addr;
	logic [RW-1:0]     mem_wdata, mem_rdata;

	logic [AW-1:0]     host_part, n_wide, h_wide;
	logic [HB-1:0]     host_cnt, start_sel, loc_idx;
	logic              net_ok, h_bad;
	logic [RB-1:0]     loc_off;
	logic [RW-1:0]     loc_bit;

	logic [RW-1:0]     scan_mask, scan_free;
	logic              scan_hit;
	logic [RB-1:0]     scan_pos;
	logic [HB-1:0]     scan_inc, scan_next;
	logic [RI-1:0]     start_row, last_row;
	logic              accept, put_done;

	// host count and address checks
	always_comb begin
		host_part = ~mask_q;
		n_wide    = (host_part == '0) ? '0 : host_part - 1'b1;
		host_cnt  = (n_wide > MAX_HOSTS) ? MAX_HOSTS[HB-1:0] : n_wide[HB-1:0];
		net_ok    = (addr_q & mask_q) == (base_q & mask_q);
		h_wide    = addr_q & ~mask_q;
		h_bad     = (h_wide == '0) || (h_wide > AW'(n_q));
		loc_idx   = h_wide[HB-1:0] - 1'b1;
		loc_off   = idx_q[RB-1:0];
		loc_bit   = RW'(1) << loc_off;
		start_sel = (next_q < n_q) ? next_q : '0;
	end

	// row scan: mask the row to the search window and find the first free bit
	always_comb begin
		start_row = start_q[HB-1:RB];
		last_row  = last_q[HB-1:RB];
		scan_mask = '1;
		if (!phase_b_q) begin
			if (row_q == start_row) begin
				scan_mask = scan_mask & ({RW{1'b1}} << start_q[RB-1:0]);
			end
			if (row_q == last_row) begin
				scan_mask = scan_mask & ({RW{1'b1}} >> ~last_q[RB-1:0]);
			end
		end else if (row_q == start_row) begin
			scan_mask = ~({RW{1'b1}} << start_q[RB-1:0]);
		end
		scan_free = ~mem_rdata & scan_mask;
		scan_hit  = 1'b0;
		scan_pos  = '0;
		for (int i = RW - 1; i >= 0; i--) begin
			if (scan_free[i]) begin
				scan_hit = 1'b1;
				scan_pos = RB'(i);
			end
		end
		scan_inc  = {row_q, scan_pos} + 1'b1;
		scan_next = (scan_inc < n_q) ? scan_inc : '0;
	end

	assign accept   = req.valid && req.ready;
	assign put_done = (state_q == sapa_pkg::S_PUT) && (!rsp_valid_q || rsp.ready);

	// sequencer
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = row_q;
		mem_wdata = '0;
		req.ready = 1'b0;
		unique case (state_q)
			sapa_pkg::S_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
				if (clr_q == '1) begin
					state_d = sapa_pkg::S_IDLE;
				end
			end
			sapa_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = sapa_pkg::S_DECODE;
				end
			end
			sapa_pkg::S_DECODE: begin
				state_d = sapa_pkg::S_PUT;
				case (cmd_q)
					sapa_pkg::CMD_ALLOC: begin
						if (n_q != '0) begin
							mem_re   = 1'b1;
							mem_addr = start_sel[HB-1:RB];
							state_d  = sapa_pkg::S_SCAN;
						end
					end
					sapa_pkg::CMD_CLAIM, sapa_pkg::CMD_RELEASE: begin
						if (net_ok && !h_bad) begin
							mem_re   = 1'b1;
							mem_addr = loc_idx[HB-1:RB];
							state_d  = sapa_pkg::S_MODIFY;
						end
					end
					default: begin
						state_d = sapa_pkg::S_PUT;
					end
				endcase
			end
			sapa_pkg::S_MODIFY: begin
				mem_addr = idx_q[HB-1:RB];
				if (cmd_q == sapa_pkg::CMD_CLAIM) begin
					mem_we    = (mem_rdata & loc_bit) == '0;
					mem_wdata = mem_rdata | loc_bit;
				end else begin
					mem_we    = 1'b1;
					mem_wdata = mem_rdata & ~loc_bit;
				end
				state_d = sapa_pkg::S_PUT;
			end
			sapa_pkg::S_SCAN: begin
				if (scan_hit) begin
					state_d = sapa_pkg::S_PUT;
				end else if (!phase_b_q && row_q == last_row) begin
					// wrap: continue from row zero up to the start row
					mem_re   = 1'b1;
					mem_addr = '0;
				end else if (phase_b_q && row_q == start_row) begin
					state_d = sapa_pkg::S_PUT;
				end else begin
					mem_re   = 1'b1;
					mem_addr = row_q + 1'b1;
				end
			end
			sapa_pkg::S_PUT: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = sapa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sapa_pkg::S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sapa_pkg::S_CLEAR;
			clr_q       <= '0;
			base_q      <= '0;
			mask_q      <= sapa_pkg::MASK_RESET;
			next_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sapa_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				unique case (sapa_pkg::cfg_reg_t'(cfg_index))
					sapa_pkg::CFG_SUBNET_BASE: base_q <= cfg_data;
					sapa_pkg::CFG_SUBNET_MASK: mask_q <= cfg_data;
				endcase
			end
			if (state_q == sapa_pkg::S_SCAN && scan_hit) begin
				next_q <= scan_next;
			end
			if (put_done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= sapa_pkg::cmd_t'(req.command);
			addr_q <= req.address;
			n_q    <= host_cnt;
		end
		case (state_q)
			sapa_pkg::S_DECODE: begin
				res_addr_q   <= '0;
				res_status_q <= sapa_pkg::ST_OK;
				case (cmd_q)
					sapa_pkg::CMD_ALLOC: begin
						if (n_q == '0) begin
							res_status_q <= sapa_pkg::ST_EXHAUSTED;
						end else begin
							start_q   <= start_sel;
							last_q    <= n_q - 1'b1;
							row_q     <= start_sel[HB-1:RB];
							phase_b_q <= 1'b0;
						end
					end
					sapa_pkg::CMD_CLAIM, sapa_pkg::CMD_RELEASE: begin
						if (!net_ok) begin
							res_status_q <= sapa_pkg::ST_NOT_IN_SUBNET;
						end else if (h_bad) begin
							res_status_q <= sapa_pkg::ST_INVALID_HOST;
						end else begin
							idx_q <= loc_idx;
						end
					end
					default: begin
						res_status_q <= sapa_pkg::ST_OK;
					end
				endcase
			end
			sapa_pkg::S_MODIFY: begin
				if (cmd_q == sapa_pkg::CMD_CLAIM && (mem_rdata & loc_bit) != '0) begin
					res_status_q <= sapa_pkg::ST_IN_USE;
				end
			end
			sapa_pkg::S_SCAN: begin
				if (scan_hit) begin
					res_addr_q <= (base_q & mask_q) | AW'(scan_inc);
				end else if (!phase_b_q && row_q == last_row) begin
					row_q     <= '0;
					phase_b_q <= 1'b1;
				end else if (phase_b_q && row_q == start_row) begin
					res_status_q <= sapa_pkg::ST_EXHAUSTED;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (put_done) begin
			rsp_addr_q   <= res_addr_q;
			rsp_status_q <= res_status_q;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.assigned_address = rsp_addr_q;
	assign rsp.status           = rsp_status_q;

	sapa_bitmap #(
		.HOST_BITS (HOST_BITS)
	) u_bitmap (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == sapa_pkg::S_DECODE)
		else $error("accepted request did not enter decode");

	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sapa_pkg::S_SCAN |-> !mem_we)
		else $error("bitmap written during allocate scan");

	a_scan_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sapa_pkg::S_SCAN && !phase_b_q) |-> row_q <= last_row)
		else $error("scan ran past the last host row");

	a_addr_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_addr_q != '0) |-> rsp_status_q == sapa_pkg::ST_OK)
		else $error("address returned with error status");

	a_next_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sapa_pkg::S_PUT && $past(state_q == sapa_pkg::S_SCAN) && $past(scan_hit))
		|-> next_q < n_q)
		else $error("next-fit pointer beyond host count after allocate");

endmodule
